### rtl/assert_macros.svh
// Assertion macros used by the cipher core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tspn_pkg.sv
// Package for the toy SPN cipher core: constants, types, round functions.
package tspn_pkg;

  localparam int MAX_ROUNDS = 16;
  localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
  localparam int BLK_W      = 64;
  localparam int RC_W       = 5;

  localparam logic [31:0] KEY_CONST = 32'hf33ff33f;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_KEY_LOW     = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH    = 2'd1;
  localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

  // Mix matrix rows, bit k set means F[i][k] = 1
  localparam logic [3:0] MIX_ROWS [4] = '{4'h5, 4'h6, 4'h1, 4'hC};

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Key schedule controls from the sequencer
  typedef struct packed {
    logic load;
    logic advance;
  } key_ctrl_t;

  // Substitute each byte in place
  function automatic logic [63:0] sub_bytes(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      r[8*b +: 8] = SBOX[x[8*b +: 8]];
    end
    return r;
  endfunction

  // Nibble matrix mix over GF(2); m[k][j] is nibble 4*(3-j)+(3-k)
  function automatic logic [63:0] mix(input logic [63:0] x);
    logic [63:0] r;
    logic [3:0]  acc;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          if (MIX_ROWS[i][k]) begin
            acc = acc ^ x[4*(4*(3-j) + (3-k)) +: 4];
          end
        end
        r[4*(15 - i - 4*j) +: 4] = acc;
      end
    end
    return r;
  endfunction

endpackage

### rtl/tspn_round.sv
// One cipher round: round key add, byte substitution, nibble mix.
module tspn_round (
  input  logic [63:0] blk,
  input  logic [63:0] subkey,
  output logic [63:0] blk_out
);

  logic [63:0] keyed;
  logic [63:0] subbed;

  // Add key, substitute, mix
  assign keyed   = blk ^ subkey;
  assign subbed  = tspn_pkg::sub_bytes(keyed);
  assign blk_out = tspn_pkg::mix(subbed);

endmodule

### rtl/tspn_keysched.sv
// Key schedule register: 128-bit key, one step per round.
module tspn_keysched (
  input  logic                clk,
  input  tspn_pkg::key_ctrl_t ctrl,
  input  logic [63:0]         key_low,
  input  logic [63:0]         key_high,
  output logic [63:0]         subkey
);

  logic [63:0] klo;
  logic [63:0] khi;
  logic [63:0] klo_x;

  // Fold the constant into the low word before rotating
  assign klo_x = {klo[63:32], klo[31:0] ^ tspn_pkg::KEY_CONST};

  // Load at item start, rotate right by 32 each round
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      klo <= key_low;
      khi <= key_high;
    end else if (ctrl.advance) begin
      klo <= {khi[31:0], klo_x[63:32]};
      khi <= {klo_x[31:0], khi[63:32]};
    end
  end

  assign subkey = klo;

endmodule

### rtl/toy_spn_block_cipher_core.sv
// Top level of the toy SPN block cipher core.
// Usage:
//   Configuration: wr_en, wr_index, wr_data. Index 0 writes key_low, 1 key_high,
//   2 round_count (low 5 bits); other indexes are ignored. Write only while idle.
//   Input: drive plaintext and raise start; the item is taken at a clock edge
//   where start is high and busy is low. The key and round count are captured then.
//   Output: done pulses for one cycle with ciphertext valid; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   From the accepting edge the core runs R rounds, where R is round_count
//   saturated to 16, one round per cycle through the single shared round unit,
//   with the key register stepping alongside; then ciphertext and done are
//   registered together. Items do not overlap: busy stays high through the
//   cycle that delivers, and start may be raised again in the done cycle.
//   Reset: rst (synchronous) returns key_low to 1, key_high to 0, round_count
//   to 1, and drops any item in progress.
`include "assert_macros.svh"

module toy_spn_block_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        start,
  input  logic [63:0] plaintext,
  output logic        busy,
  output logic        done,
  output logic [63:0] ciphertext
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t                       state;
  logic [63:0]                  key_low;
  logic [63:0]                  key_high;
  logic [tspn_pkg::RC_W-1:0]    round_count;
  logic [tspn_pkg::CNT_W-1:0]   rounds;
  logic [tspn_pkg::CNT_W-1:0]   rounds_next;
  logic [tspn_pkg::CNT_W-1:0]   cnt;
  logic [63:0]                  blk;
  logic [63:0]                  blk_round;
  logic [63:0]                  subkey;
  logic                         accept;
  logic                         last;
  tspn_pkg::key_ctrl_t          key_ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= 64'd1;
      key_high    <= 64'd0;
      round_count <= tspn_pkg::RC_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        tspn_pkg::REG_KEY_LOW:     key_low     <= wr_data;
        tspn_pkg::REG_KEY_HIGH:    key_high    <= wr_data;
        tspn_pkg::REG_ROUND_COUNT: round_count <= wr_data[tspn_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the round count
  assign rounds_next = (int'(round_count) > tspn_pkg::MAX_ROUNDS) ?
                       tspn_pkg::CNT_W'(tspn_pkg::MAX_ROUNDS) :
                       tspn_pkg::CNT_W'(round_count);

  assign busy   = (state == RUN);
  assign accept = start && !busy;
  assign last   = (cnt == rounds);

  assign key_ctrl.load    = accept;
  assign key_ctrl.advance = busy && !last;

  tspn_keysched u_keysched (
    .clk      (clk),
    .ctrl     (key_ctrl),
    .key_low  (key_low),
    .key_high (key_high),
    .subkey   (subkey)
  );

  tspn_round u_round (
    .blk     (blk),
    .subkey  (subkey),
    .blk_out (blk_round)
  );

  // Sequencer: load, iterate rounds, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (last) begin
            state <= IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      blk    <= plaintext;
      cnt    <= '0;
      rounds <= rounds_next;
    end else if (busy) begin
      if (last) begin
        ciphertext <= blk;
      end else begin
        blk <= blk_round;
        cnt <= cnt + tspn_pkg::CNT_W'(1);
      end
    end
  end

  `ASSERT_NEXT(a_start_runs, clk, rst, accept, busy)
  `ASSERT_IMPLIES(a_cnt_bound, clk, rst, busy, cnt <= rounds)
  `ASSERT_IMPLIES(a_done_after_run, clk, rst, done, $past(busy) && !busy)
  `ASSERT_NEXT(a_last_done, clk, rst, busy && last, done && !busy)

endmodule

### tb/toy_spn_block_cipher_core_test.sv
// Testbench for the toy SPN block cipher core: directed and random blocks vs. a predictor.
`timescale 1ns / 100ps

module toy_spn_block_cipher_core_test;

  // Index past the register list; writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_BLOCKS = 1850;

  typedef struct {
    logic [63:0] plaintext;
    logic [63:0] ciphertext;
  } cipher_pair_t;

  // Predicts ciphertexts from a private copy of the key and round count
  class cipher_tracker;
    logic [63:0]               key_lo;
    logic [63:0]               key_hi;
    logic [tspn_pkg::RC_W-1:0] rounds;
    cipher_pair_t              pending_q[$];
    int unsigned               checked;
    int unsigned               mismatches;

    function new();
      key_lo     = 64'd1;
      key_hi     = 64'd0;
      rounds     = 5'd1;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void store_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        tspn_pkg::REG_KEY_LOW:     key_lo = data;
        tspn_pkg::REG_KEY_HIGH:    key_hi = data;
        tspn_pkg::REG_ROUND_COUNT: rounds = data[tspn_pkg::RC_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] substitute(logic [63:0] x);
      logic [63:0] y;
      y = '0;
      for (int b = 0; b < 8; b++) y[8*b +: 8] = tspn_pkg::SBOX[x[8*b +: 8]];
      return y;
    endfunction

    // Lay nibbles out as a 4x4 grid and multiply by the fixed binary matrix
    function logic [63:0] mix_nibbles(logic [63:0] x);
      logic [3:0]  grid [4][4];
      logic [3:0]  acc;
      logic [63:0] y;
      y = '0;
      for (int n = 0; n < 16; n++) grid[3 - n % 4][3 - n / 4] = x[4*n +: 4];
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          acc = '0;
          for (int k = 0; k < 4; k++) begin
            if (tspn_pkg::MIX_ROWS[i][k]) acc = acc ^ grid[k][j];
          end
          y[4*(15 - i - 4*j) +: 4] = acc;
        end
      end
      return y;
    endfunction

    function logic [63:0] encrypt_block(logic [63:0] pt);
      logic [127:0] sched;
      logic [63:0]  blk;
      int           n_rounds;
      n_rounds = (int'(rounds) > tspn_pkg::MAX_ROUNDS) ? tspn_pkg::MAX_ROUNDS : int'(rounds);
      sched    = {key_hi, key_lo};
      blk      = pt;
      for (int r = 0; r < n_rounds; r++) begin
        blk          = mix_nibbles(substitute(blk ^ sched[63:0]));
        sched[31:0]  = sched[31:0] ^ tspn_pkg::KEY_CONST;
        sched        = {sched[31:0], sched[127:32]};
      end
      return blk;
    endfunction

    function void note_plaintext(logic [63:0] pt);
      cipher_pair_t pair;
      pair.plaintext  = pt;
      pair.ciphertext = encrypt_block(pt);
      pending_q.push_back(pair);
    endfunction

    function void check_ciphertext(logic [63:0] ct);
      cipher_pair_t pair;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected ciphertext: expected none, got %h", $time, ct);
        return;
      end
      pair = pending_q.pop_front();
      checked++;
      if (ct !== pair.ciphertext) begin
        mismatches++;
        $display("%0t: ciphertext for plaintext %h: expected %h, got %h",
                 $time, pair.plaintext, pair.ciphertext, ct);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [63:0] wr_data;
  logic        start;
  logic [63:0] plaintext;
  logic        busy;
  logic        done;
  logic [63:0] ciphertext;

  cipher_tracker tracker;
  int unsigned   blocks_sent;
  int unsigned   settings_used;

  toy_spn_block_cipher_core DUT (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .start      (start),
    .plaintext  (plaintext),
    .busy       (busy),
    .done       (done),
    .ciphertext (ciphertext)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each ciphertext in the cycle that done marks
  always @(posedge clk) begin
    if (!rst && done) tracker.check_ciphertext(ciphertext);
  end

  // Offer one item, idling first at the given percentage, and hold until taken
  task automatic send_block(input logic [63:0] pt, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start     <= 1'b1;
    plaintext <= pt;
    do @(posedge clk); while (busy);
    tracker.note_plaintext(pt);
    blocks_sent++;
  endtask

  // Drop start and wait until every ciphertext has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || tracker.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic drive_reg(input logic [1:0] idx, input logic [63:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    tracker.store_reg(idx, data);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] klo, input logic [63:0] khi,
                           input logic [63:0] rc_word);
    wait_idle();
    drive_reg(tspn_pkg::REG_KEY_LOW, klo);
    drive_reg(tspn_pkg::REG_KEY_HIGH, khi);
    drive_reg(tspn_pkg::REG_ROUND_COUNT, rc_word);
    settings_used++;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly random, with the all-zero and all-one extremes now and then
  function automatic logic [63:0] rand_block();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return rand_word();
    endcase
  endfunction

  // Pick a new key and round count; round counts past the limit must saturate
  task automatic pick_settings();
    logic [63:0] rc_word;
    rc_word = rand_word();
    case ($urandom_range(7))
      0:       rc_word[tspn_pkg::RC_W-1:0] = 5'd0;
      1:       rc_word[tspn_pkg::RC_W-1:0] = 5'd16;
      2:       rc_word[tspn_pkg::RC_W-1:0] = 5'($urandom_range(31, 17));
      default: rc_word[tspn_pkg::RC_W-1:0] = 5'($urandom_range(16, 1));
    endcase
    configure(rand_block(), rand_block(), rc_word);
    if ($urandom_range(3) == 0) drive_reg(REG_UNUSED, rand_word());
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_len;
    int          idle_pct;
    tracker       = new();
    blocks_sent   = 0;
    settings_used = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    plaintext <= '0;
    wr_en     <= 1'b0;
    wr_index  <= '0;
    wr_data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset key and round count
    send_block(64'h0, 0);
    send_block('1, 0);

    // Zero rounds: plaintext passes through
    configure(64'h0, 64'h0, 64'h0);
    send_block('1, 0);
    send_block(64'ha5a5_5a5a_0ff0_f00f, 0);

    // Full round count, all-ones key
    configure('1, '1, 64'd16);
    send_block(64'h0, 0);
    send_block('1, 0);
    send_block(64'h8000_0000_0000_0001, 0);

    // Round counts past the limit saturate
    configure(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd31);
    send_block(64'h0, 0);
    send_block(rand_word(), 0);
    configure(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, {59'h7ff_ffff, 5'd17});
    send_block(rand_word(), 0);

    // Alternating key bits, then a write to an unused index that must change nothing
    configure(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'd5);
    send_block(64'h0123_4567_89ab_cdef, 0);
    wait_idle();
    drive_reg(REG_UNUSED, '1);
    send_block(64'h0123_4567_89ab_cdef, 0);
    send_block(rand_word(), 0);

    // Random phases, rotating through idle patterns on the sending side
    phase = 0;
    while (blocks_sent < RANDOM_BLOCKS) begin
      pick_settings();
      case (phase % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        2:       idle_pct = 0;
        default: idle_pct = 13;
      endcase
      phase_len = $urandom_range(120, 40);
      for (int unsigned k = 0; k < phase_len; k++) send_block(rand_block(), idle_pct);
      phase++;
    end

    // Drain and allow a few more cycles for any stray done
    wait_idle();
    repeat (tspn_pkg::MAX_ROUNDS + 4) @(posedge clk);
    $display("Encrypted %0d blocks under %0d key/round settings, round counts 0 to 31.",
             blocks_sent, settings_used);
    $display("Checked %0d ciphertexts, %0d mismatches.", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_q.size() == 0) begin
      $display("PASS toy_spn_block_cipher_core");
    end else begin
      if (tracker.pending_q.size() != 0)
        $display("%0t: %0d ciphertexts never arrived", $time, tracker.pending_q.size());
      $display("FAIL toy_spn_block_cipher_core");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL toy_spn_block_cipher_core");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/tspn_pkg.sv
rtl/tspn_round.sv
rtl/tspn_keysched.sv
rtl/toy_spn_block_cipher_core.sv
tb/toy_spn_block_cipher_core_test.sv
